// ----- hw/rtl/rbpf_pkg.sv -----
// Package for the router advertisement bogus prefix filter.
// Holds payload word types, verdict and error codes and the table mask function.
// Depends on nothing.
package rbpf_pkg;

    localparam int NumPrefixesDefault = 8;
    localparam int MaxMessageBytesDefault = 2048;
    localparam int EntryIndexWidth = 3;
    localparam int OptionsStart = 16;
    localparam logic [7:0] PrefixInfoKind = 8'd3;
    localparam logic [7:0] MaxPrefixLength = 8'd128;

    localparam logic [1:0] VERDICT_WITHDRAWAL = 2'd0;
    localparam logic [1:0] VERDICT_CLEAN = 2'd1;
    localparam logic [1:0] VERDICT_BOGUS = 2'd2;
    localparam logic [1:0] VERDICT_RUNT = 2'd3;

    localparam logic [1:0] PERR_NONE = 2'd0;
    localparam logic [1:0] PERR_SHORT = 2'd1;
    localparam logic [1:0] PERR_ZERO = 2'd2;
    localparam logic [1:0] PERR_TRUNC = 2'd3;

    typedef struct packed {
        logic        mode;
        logic [7:0]  msg_byte;
        logic        msg_last;
        logic [2:0]  entry_index;
        logic        entry_half;
        logic [63:0] entry_word;
        logic [7:0]  entry_length;
        logic        entry_enable;
    } in_word_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic [1:0] parse_error;
        logic [2:0] match_entry;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_byte;
        logic load_entry;
        logic cmp_start;
        logic cmp_step;
        logic finish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic option_end;
        logic cmp_last;
    } dp_status_t;

    function automatic logic [63:0] half_mask(input logic [7:0] len, input logic half);
        logic [7:0] n;
        logic [63:0] m;
        begin
            m = '0;
            n = half ? ((len > 8'd64) ? len - 8'd64 : 8'd0) : len;
            if (n >= 8'd64)
            begin
                m = '1;
            end
            else if (n != 8'd0)
            begin
                m = ~(64'hFFFF_FFFF_FFFF_FFFF >> n[5:0]);
            end
            return m;
        end
    endfunction

endpackage

// ----- hw/rtl/rbpf_ctrl.sv -----
// Controller state machine of the bogus prefix filter.
// Sequences byte intake, table compare and verdict delivery; uses rbpf_pkg.
module rbpf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                item_mode,
    input  logic                item_last,
    input  logic                out_busy,
    input  rbpf_pkg::dp_status_t status,
    output rbpf_pkg::dp_cmd_t   cmd
);
    import rbpf_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic last_reg, last_next;
    logic accept;

    assign in_ready = (state_reg == S_IDLE) && !out_busy;
    assign accept = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        last_next = last_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_entry = item_mode;
                    cmd.take_byte = !item_mode;
                    if (!item_mode)
                    begin
                        last_next = item_last;
                        if (status.option_end)
                        begin
                            cmd.cmp_start = 1'b1;
                            state_next = S_CMP;
                        end
                        else if (item_last)
                        begin
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_CMP:
            begin
                cmd.cmp_step = 1'b1;
                if (status.cmp_last)
                begin
                    state_next = last_reg ? S_DONE : S_IDLE;
                end
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg <= last_next;
        end
    end

endmodule

// ----- hw/rtl/rbpf_datapath.sv -----
// Datapath of the bogus prefix filter: message parser, prefix table, comparator.
// Compares one table entry per cycle; uses rbpf_pkg.
module rbpf_datapath #(
    parameter int NUM_PREFIXES = rbpf_pkg::NumPrefixesDefault,
    parameter int MAX_MESSAGE_BYTES = rbpf_pkg::MaxMessageBytesDefault
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rbpf_pkg::in_word_t   item,
    input  rbpf_pkg::dp_cmd_t    cmd,
    output rbpf_pkg::dp_status_t status,
    output rbpf_pkg::out_word_t  result
);
    import rbpf_pkg::*;

    localparam int PosW = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int IdxW = EntryIndexWidth;
    localparam int Slots = (NUM_PREFIXES < (1 << IdxW)) ? NUM_PREFIXES : (1 << IdxW);
    localparam int SlotW = (Slots > 1) ? $clog2(Slots) : 1;
    localparam logic [PosW-1:0] MaxPos = PosW'(MAX_MESSAGE_BYTES);

    logic [PosW-1:0] pos_reg;
    logic life_reg;
    logic [PosW-1:0] opt_off_reg;
    logic [10:0] opt_size_reg;
    logic [7:0] opt_kind_reg;
    logic [7:0] adv_len_reg;
    logic [7:0] cap_reg [16];
    logic stopped_reg;
    logic [1:0] err_reg;
    logic bogus_reg;
    logic [2:0] first_reg;
    logic [63:0] hi_word_reg [Slots];
    logic [63:0] lo_word_reg [Slots];
    logic [7:0] tlen_reg [Slots];
    logic [Slots-1:0] tvalid_reg;
    logic [SlotW-1:0] cmp_idx_reg;
    logic cmp_done_reg;

    logic in_range, in_opts;
    logic [PosW-1:0] rel;
    logic [127:0] cap_word;
    logic [7:0] elen;
    logic [SlotW-1:0] ld_idx;
    logic hit;
    logic [PosW-1:0] len_now, resid;

    assign in_range = pos_reg < MaxPos;
    assign rel = pos_reg - PosW'(OptionsStart) - opt_off_reg;
    assign in_opts = in_range && !stopped_reg && (pos_reg >= PosW'(OptionsStart))
                     && (pos_reg - PosW'(OptionsStart) >= opt_off_reg);
    assign status.option_end = in_opts && (rel >= PosW'(2))
                     && ({{(PosW > 11 ? PosW - 11 : 0){1'b0}}, opt_size_reg} - 1 == rel)
                     && (opt_kind_reg == PrefixInfoKind) && (opt_size_reg == 11'd32)
                     && (adv_len_reg <= MaxPrefixLength);
    assign status.cmp_last = hit || cmp_done_reg || (cmp_idx_reg == SlotW'(Slots - 1));

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            cap_word[127 - 8*i -: 8] = cap_reg[i];
        end
    end

    assign elen = (item.entry_length > MaxPrefixLength) ? MaxPrefixLength : item.entry_length;
    assign ld_idx = SlotW'(item.entry_index);
    assign hit = !cmp_done_reg && tvalid_reg[cmp_idx_reg]
                 && (tlen_reg[cmp_idx_reg] <= adv_len_reg)
                 && ((cap_word[127:64] & half_mask(tlen_reg[cmp_idx_reg], 1'b0))
                     == hi_word_reg[cmp_idx_reg])
                 && ((cap_word[63:0] & half_mask(tlen_reg[cmp_idx_reg], 1'b1))
                     == lo_word_reg[cmp_idx_reg]);

    always_ff @(posedge clk)
    begin
        if (cmd.take_byte && in_opts && rel >= PosW'(16) && rel < PosW'(32))
        begin
            cap_reg[rel[3:0]] <= item.msg_byte;
        end
        if (cmd.load_entry && ({29'd0, item.entry_index} < NUM_PREFIXES))
        begin
            if (item.entry_half)
            begin
                lo_word_reg[ld_idx] <= item.entry_word & half_mask(elen, 1'b1);
            end
            else
            begin
                hi_word_reg[ld_idx] <= item.entry_word & half_mask(elen, 1'b0);
            end
            tlen_reg[ld_idx] <= elen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            life_reg <= 1'b0;
            opt_off_reg <= '0;
            opt_size_reg <= '0;
            opt_kind_reg <= '0;
            adv_len_reg <= '0;
            stopped_reg <= 1'b0;
            err_reg <= PERR_NONE;
            bogus_reg <= 1'b0;
            first_reg <= '0;
            tvalid_reg <= '0;
            cmp_idx_reg <= '0;
            cmp_done_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_entry && ({29'd0, item.entry_index} < NUM_PREFIXES))
            begin
                tvalid_reg[ld_idx] <= item.entry_enable;
            end
            if (cmd.take_byte && in_range)
            begin
                pos_reg <= pos_reg + 1'b1;
                if ((pos_reg == PosW'(6) || pos_reg == PosW'(7)) && item.msg_byte != 8'd0)
                begin
                    life_reg <= 1'b1;
                end
                if (in_opts)
                begin
                    if (rel == '0)
                    begin
                        opt_kind_reg <= item.msg_byte;
                    end
                    else if (rel == PosW'(1))
                    begin
                        if (item.msg_byte == 8'd0)
                        begin
                            stopped_reg <= 1'b1;
                            err_reg <= PERR_ZERO;
                        end
                        else
                        begin
                            opt_size_reg <= {item.msg_byte, 3'b000};
                        end
                    end
                    else
                    begin
                        if (rel == PosW'(2))
                        begin
                            adv_len_reg <= item.msg_byte;
                        end
                        if ({{(PosW > 11 ? PosW - 11 : 0){1'b0}}, opt_size_reg} - 1 == rel)
                        begin
                            opt_off_reg <= opt_off_reg + PosW'(opt_size_reg);
                        end
                    end
                end
            end
            if (cmd.cmp_start)
            begin
                cmp_idx_reg <= '0;
                cmp_done_reg <= 1'b0;
            end
            else if (cmd.cmp_step)
            begin
                if (hit && !bogus_reg)
                begin
                    bogus_reg <= 1'b1;
                    first_reg <= 3'(cmp_idx_reg);
                end
                if (hit)
                begin
                    cmp_done_reg <= 1'b1;
                end
                if (cmp_idx_reg != SlotW'(Slots - 1))
                begin
                    cmp_idx_reg <= cmp_idx_reg + 1'b1;
                end
            end
            if (cmd.finish)
            begin
                pos_reg <= '0;
                life_reg <= 1'b0;
                opt_off_reg <= '0;
                opt_size_reg <= '0;
                opt_kind_reg <= '0;
                adv_len_reg <= '0;
                stopped_reg <= 1'b0;
                err_reg <= PERR_NONE;
                bogus_reg <= 1'b0;
                first_reg <= '0;
            end
        end
    end

    assign len_now = pos_reg;
    assign resid = len_now - PosW'(OptionsStart) - opt_off_reg;

    always_comb
    begin
        result = '0;
        if (len_now < PosW'(8))
        begin
            result.verdict = VERDICT_RUNT;
        end
        else if (!life_reg)
        begin
            result.verdict = VERDICT_WITHDRAWAL;
        end
        else
        begin
            result.parse_error = err_reg;
            if (!stopped_reg && len_now > PosW'(OptionsStart) + opt_off_reg)
            begin
                result.parse_error = (resid < PosW'(2)) ? PERR_SHORT : PERR_TRUNC;
            end
            result.verdict = bogus_reg ? VERDICT_BOGUS : VERDICT_CLEAN;
            result.match_entry = bogus_reg ? first_reg : 3'd0;
        end
    end

endmodule

// ----- hw/rtl/ra_bogus_prefix_filter.sv -----
// Top level of the router advertisement bogus prefix filter.
// Joins rbpf_ctrl and rbpf_datapath and holds the output register; uses rbpf_pkg.
//
//  channel   direction   handshake            word
//  in        input       in_valid/in_ready    rbpf_pkg::in_word_t
//  out       output      out_valid/out_ready  rbpf_pkg::out_word_t
//
// A table load or an ordinary message byte is taken in S_IDLE and leaves it in S_IDLE.
// A prefix option's end byte starts S_CMP over the NUM_PREFIXES entries, at most 8.
// After the last byte, S_DONE moves the verdict into the output register.
// Input is held off while a verdict waits to be taken. Reset empties the table.
module ra_bogus_prefix_filter #(
    parameter int NUM_PREFIXES = rbpf_pkg::NumPrefixesDefault,
    parameter int MAX_MESSAGE_BYTES = rbpf_pkg::MaxMessageBytesDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rbpf_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output rbpf_pkg::out_word_t out_data
);
    import rbpf_pkg::*;

    dp_cmd_t cmd;
    dp_status_t status;
    out_word_t result;
    logic out_valid_reg;
    out_word_t out_data_reg;

    rbpf_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .item_mode(in_data.mode),
        .item_last(in_data.msg_last),
        .out_busy(out_valid_reg),
        .status(status),
        .cmd(cmd)
    );

    rbpf_datapath #(
        .NUM_PREFIXES(NUM_PREFIXES),
        .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
    ) u_datapath (
        .clk(clk),
        .rst_n(rst_n),
        .item(in_data),
        .cmd(cmd),
        .status(status),
        .result(result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    a_no_accept_while_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !in_ready)
        else $error("input accepted while a verdict waits");

    a_finish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("verdict not presented after finish");

    a_single_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.take_byte, cmd.load_entry, cmd.cmp_step, cmd.finish}))
        else $error("conflicting datapath commands");

endmodule
